>>> rtl/mlat_pkg.sv
// Shared types, widths and constants of the multilateration position solver.
package mlat_pkg;

    localparam int COORD_W     = 16;
    localparam int ANCHOR_W    = 3 * COORD_W;
    localparam int NUM_ANCHORS = 4;
    localparam int NUM_AXES    = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int RANGE_W     = 16;
    localparam int POS_W       = 24;

    localparam int A_W    = COORD_W + 2;
    localparam int SQF_W  = 2 * COORD_W;
    localparam int SQC_W  = 2 * COORD_W - 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int COF_W  = 2 * A_W;
    localparam int DP_W   = A_W + COF_W;
    localparam int DET_W  = DP_W + 2;
    localparam int E_W    = SQ_W + 2;
    localparam int RR_W   = 2 * RANGE_W;
    localparam int B_W    = RR_W + 3;
    localparam int BLO_W  = 18;
    localparam int BHI_W  = B_W - BLO_W;
    localparam int PLO_W  = COF_W + BLO_W + 1;
    localparam int PHI_W  = COF_W + BHI_W;
    localparam int NUM_W  = 72;
    localparam int FRAC_SH = 9;
    localparam int REM_W  = 83;

    localparam int DIV_BITS      = POS_W;
    localparam int NUM_STAGES    = 7;
    localparam int PIPE_STAGES   = NUM_STAGES + DIV_BITS + 1;
    localparam int SETTLE_W      = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_REF = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_B   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_C   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_D   = 8'd3;

    localparam logic [ANCHOR_W-1:0] ANCHOR_REF_RST = 48'd30;
    localparam logic [ANCHOR_W-1:0] ANCHOR_B_RST   = 48'd0;
    localparam logic [ANCHOR_W-1:0] ANCHOR_C_RST   = 48'd1966080;
    localparam logic [ANCHOR_W-1:0] ANCHOR_D_RST   = 48'd128849018880;

    localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
    localparam logic [POS_W-1:0] NEG_MAG = 24'h800000;

    typedef struct packed {
        logic [RANGE_W-1:0] range_ref;
        logic [RANGE_W-1:0] range_b;
        logic [RANGE_W-1:0] range_c;
        logic [RANGE_W-1:0] range_d;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    singular;
    } t_out;

endpackage

>>> rtl/multilateration_position_solver_top.sv
// Top level of the four-anchor multilateration position solver.
//
// Input channel i_in_valid / o_in_ready carries one item: four measured ranges.
// Output channel o_out_valid / i_out_ready returns one item per input item:
// the position with 8 fraction bits, rounded and saturated, and a singular flag.
// Configuration channel i_cfg_valid / o_cfg_ready writes the four anchor
// registers by index; indexes beyond the fourth are ignored.
// The solver is a 32-stage pipeline: seven stages form the right-hand side and
// the adjugate numerators, 24 stages run a restoring divider with one quotient
// bit per stage, and a final stage saturates into the output register.
// One item per cycle is taken for as long as the output side keeps up.
// Each stage moves on when it is empty or the stage after it moves, so a stall
// at the output fills bubbles first and holds every result in place.
// After reset, and after every configuration write, o_in_ready stays low while
// the geometry pipeline recomputes the cofactors and the determinant from the
// anchor registers.
// Reset loads the default anchor layout and empties the pipeline.
module multilateration_position_solver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mlat_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mlat_pkg::t_out                      o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mlat_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mlat_pkg::ANCHOR_W-1:0]       i_cfg_data
);

    localparam int NS   = mlat_pkg::PIPE_STAGES;
    localparam int LAST = NS - 1;

    logic [mlat_pkg::ANCHOR_W-1:0]     r_anchor [mlat_pkg::NUM_ANCHORS];
    logic [mlat_pkg::SETTLE_W-1:0]     r_settle;
    logic [NS-1:0]                     r_v;
    logic [NS-1:0]                     w_en;
    logic                              w_in_acc;
    logic                              w_cfg_acc;

    logic signed [mlat_pkg::COF_W-1:0] w_cof [3][3];
    logic signed [mlat_pkg::E_W-1:0]   w_e [3];
    logic [mlat_pkg::DET_W-1:0]        w_det_mag;
    logic                              w_det_neg;
    logic                              w_singular;
    logic [mlat_pkg::REM_W-1:0]        w_rem [3];
    logic                              w_neg [3];
    logic [mlat_pkg::DIV_BITS-1:0]     w_q [3];
    logic                              w_ovf [3];
    logic                              w_qneg [3];
    logic [mlat_pkg::POS_W-1:0]        w_pos [3];
    mlat_pkg::t_out                    w_res;
    mlat_pkg::t_out                    r_out;

    assign w_en[LAST] = !r_v[LAST] || i_out_ready;
    for (genvar g = 0; g < LAST; g++) begin : g_en
        assign w_en[g] = !r_v[g] || w_en[g+1];
    end

    assign o_in_ready  = w_en[0] && (r_settle == '0);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor[0] <= mlat_pkg::ANCHOR_REF_RST;
            r_anchor[1] <= mlat_pkg::ANCHOR_B_RST;
            r_anchor[2] <= mlat_pkg::ANCHOR_C_RST;
            r_anchor[3] <= mlat_pkg::ANCHOR_D_RST;
            r_settle    <= mlat_pkg::SETTLE_CYCLES;
        end else if (w_cfg_acc) begin
            r_settle <= mlat_pkg::SETTLE_CYCLES;
            case (i_cfg_index)
                mlat_pkg::CFG_ANCHOR_REF: r_anchor[0] <= i_cfg_data;
                mlat_pkg::CFG_ANCHOR_B:   r_anchor[1] <= i_cfg_data;
                mlat_pkg::CFG_ANCHOR_C:   r_anchor[2] <= i_cfg_data;
                mlat_pkg::CFG_ANCHOR_D:   r_anchor[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_in_acc;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    mlat_geom u_geom (
        .i_clk      (i_clk),
        .i_anchor   (r_anchor),
        .o_cof      (w_cof),
        .o_e        (w_e),
        .o_det_mag  (w_det_mag),
        .o_det_neg  (w_det_neg),
        .o_singular (w_singular)
    );

    mlat_numer u_numer (
        .i_clk     (i_clk),
        .i_en      (w_en[mlat_pkg::NUM_STAGES-1:0]),
        .i_in      (i_in),
        .i_cof     (w_cof),
        .i_e       (w_e),
        .i_det_mag (w_det_mag),
        .i_det_neg (w_det_neg),
        .o_rem     (w_rem),
        .o_neg     (w_neg)
    );

    for (genvar c = 0; c < 3; c++) begin : g_div
        mlat_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en[mlat_pkg::NUM_STAGES +: mlat_pkg::DIV_BITS]),
            .i_rem (w_rem[c]),
            .i_neg (w_neg[c]),
            .i_d2  ({w_det_mag, 1'b0}),
            .o_q   (w_q[c]),
            .o_ovf (w_ovf[c]),
            .o_neg (w_qneg[c])
        );
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (w_singular) begin
                w_pos[c] = '0;
            end else if (w_qneg[c]) begin
                w_pos[c] = (w_ovf[c] || (w_q[c] > mlat_pkg::NEG_MAG)) ? mlat_pkg::NEG_MAG
                                                                       : -w_q[c];
            end else begin
                w_pos[c] = (w_ovf[c] || (w_q[c] > mlat_pkg::POS_MAX)) ? mlat_pkg::POS_MAX
                                                                       : w_q[c];
            end
        end
        w_res.pos_x    = signed'(w_pos[0]);
        w_res.pos_y    = signed'(w_pos[1]);
        w_res.pos_z    = signed'(w_pos[2]);
        w_res.singular = w_singular;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_v[LAST];
    assign o_out       = r_out;

endmodule

>>> rtl/mlat_geom.sv
// Anchor geometry pipeline: matrix rows, cofactors, determinant and range offsets.
module mlat_geom (
    input  logic                                       i_clk,
    input  logic [mlat_pkg::ANCHOR_W-1:0]              i_anchor [mlat_pkg::NUM_ANCHORS],
    output logic signed [mlat_pkg::COF_W-1:0]          o_cof [3][3],
    output logic signed [mlat_pkg::E_W-1:0]            o_e [3],
    output logic [mlat_pkg::DET_W-1:0]                 o_det_mag,
    output logic                                       o_det_neg,
    output logic                                       o_singular
);

    logic signed [mlat_pkg::COORD_W-1:0] w_p   [mlat_pkg::NUM_ANCHORS][3];
    logic signed [mlat_pkg::SQF_W-1:0]   w_sqf [mlat_pkg::NUM_ANCHORS][3];

    logic signed [mlat_pkg::A_W-1:0]     r_a   [3][3];
    logic [mlat_pkg::SQC_W-1:0]          r_sqc [mlat_pkg::NUM_ANCHORS][3];
    logic signed [mlat_pkg::COF_W-1:0]   r_cof [3][3];
    logic [mlat_pkg::SQ_W-1:0]           r_sq  [mlat_pkg::NUM_ANCHORS];
    logic signed [mlat_pkg::E_W-1:0]     r_e   [3];
    logic signed [mlat_pkg::DP_W-1:0]    r_dp  [3];
    logic signed [mlat_pkg::DET_W-1:0]   r_det;
    logic [mlat_pkg::DET_W-1:0]          r_det_mag;
    logic                                r_det_neg;
    logic                                r_singular;

    always_comb begin
        for (int k = 0; k < mlat_pkg::NUM_ANCHORS; k++) begin
            for (int c = 0; c < 3; c++) begin
                w_p[k][c]   = signed'(i_anchor[k][mlat_pkg::COORD_W*c +: mlat_pkg::COORD_W]);
                w_sqf[k][c] = mlat_pkg::SQF_W'(w_p[k][c]) * mlat_pkg::SQF_W'(w_p[k][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                r_a[k][c] <= (mlat_pkg::A_W'(w_p[0][c]) - mlat_pkg::A_W'(w_p[k+1][c])) <<< 1;
            end
        end
        for (int k = 0; k < mlat_pkg::NUM_ANCHORS; k++) begin
            for (int c = 0; c < 3; c++) begin
                r_sqc[k][c] <= w_sqf[k][c][mlat_pkg::SQC_W-1:0];
            end
        end

        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                r_cof[k][c] <= mlat_pkg::COF_W'(r_a[(k+1)%3][(c+1)%3])
                             * mlat_pkg::COF_W'(r_a[(k+2)%3][(c+2)%3])
                             - mlat_pkg::COF_W'(r_a[(k+1)%3][(c+2)%3])
                             * mlat_pkg::COF_W'(r_a[(k+2)%3][(c+1)%3]);
            end
        end
        for (int k = 0; k < mlat_pkg::NUM_ANCHORS; k++) begin
            r_sq[k] <= mlat_pkg::SQ_W'(r_sqc[k][0]) + mlat_pkg::SQ_W'(r_sqc[k][1])
                     + mlat_pkg::SQ_W'(r_sqc[k][2]);
        end

        for (int k = 0; k < 3; k++) begin
            r_e[k] <= mlat_pkg::E_W'(r_sq[0]) - mlat_pkg::E_W'(r_sq[k+1]);
        end
        for (int c = 0; c < 3; c++) begin
            r_dp[c] <= mlat_pkg::DP_W'(r_a[0][c]) * mlat_pkg::DP_W'(r_cof[0][c]);
        end

        r_det <= mlat_pkg::DET_W'(r_dp[0]) + mlat_pkg::DET_W'(r_dp[1])
               + mlat_pkg::DET_W'(r_dp[2]);

        r_det_neg  <= r_det[mlat_pkg::DET_W-1];
        r_det_mag  <= r_det[mlat_pkg::DET_W-1] ? mlat_pkg::DET_W'(-r_det)
                                               : mlat_pkg::DET_W'(r_det);
        r_singular <= (r_det == '0);
    end

    assign o_cof      = r_cof;
    assign o_e        = r_e;
    assign o_det_mag  = r_det_mag;
    assign o_det_neg  = r_det_neg;
    assign o_singular = r_singular;

endmodule

>>> rtl/mlat_numer.sv
// Item pipeline front end: right-hand side, adjugate products and scaled numerators.
module mlat_numer (
    input  logic                                  i_clk,
    input  logic [mlat_pkg::NUM_STAGES-1:0]       i_en,
    input  mlat_pkg::t_in                         i_in,
    input  logic signed [mlat_pkg::COF_W-1:0]     i_cof [3][3],
    input  logic signed [mlat_pkg::E_W-1:0]       i_e [3],
    input  logic [mlat_pkg::DET_W-1:0]            i_det_mag,
    input  logic                                  i_det_neg,
    output logic [mlat_pkg::REM_W-1:0]            o_rem [3],
    output logic                                  o_neg [3]
);

    logic [mlat_pkg::RANGE_W-1:0]      r_r    [mlat_pkg::NUM_ANCHORS];
    logic [mlat_pkg::RR_W-1:0]         r_rr   [mlat_pkg::NUM_ANCHORS];
    logic signed [mlat_pkg::B_W-1:0]   r_b    [3];
    logic signed [mlat_pkg::PLO_W-1:0] r_plo  [3][3];
    logic signed [mlat_pkg::PHI_W-1:0] r_phi  [3][3];
    logic signed [mlat_pkg::NUM_W-1:0] r_prod [3][3];
    logic signed [mlat_pkg::NUM_W-1:0] r_num  [3];
    logic [mlat_pkg::REM_W-1:0]        r_rem  [3];
    logic                              r_neg  [3];
    logic [mlat_pkg::NUM_W-1:0]        w_mag  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_mag[c] = r_num[c][mlat_pkg::NUM_W-1] ? mlat_pkg::NUM_W'(-r_num[c])
                                                   : mlat_pkg::NUM_W'(r_num[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_r[0] <= i_in.range_ref;
            r_r[1] <= i_in.range_b;
            r_r[2] <= i_in.range_c;
            r_r[3] <= i_in.range_d;
        end
        if (i_en[1]) begin
            for (int k = 0; k < mlat_pkg::NUM_ANCHORS; k++) begin
                r_rr[k] <= r_r[k] * r_r[k];
            end
        end
        if (i_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_b[k] <= mlat_pkg::B_W'(r_rr[k+1]) - mlat_pkg::B_W'(r_rr[0])
                        + mlat_pkg::B_W'(i_e[k]);
            end
        end
        if (i_en[3]) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_plo[k][c] <= mlat_pkg::PLO_W'(i_cof[k][c])
                        * mlat_pkg::PLO_W'(signed'({1'b0, r_b[k][mlat_pkg::BLO_W-1:0]}));
                    r_phi[k][c] <= mlat_pkg::PHI_W'(i_cof[k][c])
                        * mlat_pkg::PHI_W'(signed'(r_b[k][mlat_pkg::B_W-1:mlat_pkg::BLO_W]));
                end
            end
        end
        if (i_en[4]) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[k][c] <= (mlat_pkg::NUM_W'(r_phi[k][c]) <<< mlat_pkg::BLO_W)
                                  + mlat_pkg::NUM_W'(r_plo[k][c]);
                end
            end
        end
        if (i_en[5]) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= r_prod[0][c] + r_prod[1][c] + r_prod[2][c];
            end
        end
        if (i_en[6]) begin
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= r_num[c][mlat_pkg::NUM_W-1] ^ i_det_neg;
                r_rem[c] <= (mlat_pkg::REM_W'(w_mag[c]) << mlat_pkg::FRAC_SH)
                          + mlat_pkg::REM_W'(i_det_mag);
            end
        end
    end

    assign o_rem = r_rem;
    assign o_neg = r_neg;

endmodule

>>> rtl/mlat_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detection.
module mlat_div (
    input  logic                                 i_clk,
    input  logic [mlat_pkg::DIV_BITS-1:0]        i_en,
    input  logic [mlat_pkg::REM_W-1:0]           i_rem,
    input  logic                                 i_neg,
    input  logic [mlat_pkg::DET_W:0]             i_d2,
    output logic [mlat_pkg::DIV_BITS-1:0]        o_q,
    output logic                                 o_ovf,
    output logic                                 o_neg
);

    localparam int NB = mlat_pkg::DIV_BITS;

    logic [mlat_pkg::REM_W-1:0] r_rem [NB-1];
    logic [NB-1:0]              r_q   [NB];
    logic                       r_ovf [NB];
    logic                       r_neg [NB];

    for (genvar j = 0; j < NB; j++) begin : g_step
        localparam int SH = NB - 1 - j;
        logic [mlat_pkg::REM_W-1:0] w_src;
        logic [mlat_pkg::REM_W-1:0] w_dsh;
        logic [mlat_pkg::REM_W:0]   w_diff;
        logic [NB-1:0]              w_qsrc;
        logic                       w_ovf_src;
        logic                       w_neg_src;

        if (j == 0) begin : g_first
            assign w_src     = i_rem;
            assign w_qsrc    = '0;
            assign w_ovf_src = i_rem >= (mlat_pkg::REM_W'(i_d2) << NB);
            assign w_neg_src = i_neg;
        end else begin : g_next
            assign w_src     = r_rem[j-1];
            assign w_qsrc    = r_q[j-1];
            assign w_ovf_src = r_ovf[j-1];
            assign w_neg_src = r_neg[j-1];
        end

        assign w_dsh  = mlat_pkg::REM_W'(i_d2) << SH;
        assign w_diff = {1'b0, w_src} - {1'b0, w_dsh};

        if (j < NB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= w_diff[mlat_pkg::REM_W] ? w_src
                                                        : w_diff[mlat_pkg::REM_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_q[j]   <= {w_qsrc[NB-2:0], ~w_diff[mlat_pkg::REM_W]};
                r_ovf[j] <= w_ovf_src;
                r_neg[j] <= w_neg_src;
            end
        end
    end

    assign o_q   = r_q[NB-1];
    assign o_ovf = r_ovf[NB-1];
    assign o_neg = r_neg[NB-1];

endmodule

>>> rtl/mlat_checker.sv
// Port-level checker for the multilateration position solver and its bind.
module mlat_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input mlat_pkg::t_in                       i_in,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input mlat_pkg::t_out                      o_out,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item shown right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("waiting input item changed or vanished");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result item changed or vanished");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.singular |->
            (o_out.pos_x == '0) && (o_out.pos_y == '0) && (o_out.pos_z == '0))
        else $error("singular result item carries a non-zero position");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("input item taken while geometry recomputes");

endmodule

bind multilateration_position_solver_top mlat_checker u_mlat_checker (.*);

>>> test/multilateration_position_solver_top_tb.sv
// Self-checking testbench for the four-anchor multilateration position solver.
`timescale 1ns / 1ps

module multilateration_position_solver_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int AIDX_W         = $clog2(mlat_pkg::NUM_ANCHORS);

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    mlat_pkg::t_in                  i_in;
    logic                           o_out_valid;
    logic                           i_out_ready;
    mlat_pkg::t_out                 o_out;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [mlat_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [mlat_pkg::ANCHOR_W-1:0]  i_cfg_data;

    mlat_pkg::t_in                  pending_ranges[$];
    mlat_pkg::t_out                 pos_expected[$];
    logic [mlat_pkg::ANCHOR_W-1:0]  anchor_copy[mlat_pkg::NUM_ANCHORS];
    logic                           in_taken;
    int                             mismatches;
    int                             cfg_writes;
    int                             items_sent;
    int                             results_seen;
    int                             singular_seen;
    int                             stall_free_from;
    int                             idle_cycles;

    multilateration_position_solver_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic mlat_pkg::t_out solve_position(mlat_pkg::t_in r);
        longint p[mlat_pkg::NUM_ANCHORS][mlat_pkg::NUM_AXES];
        longint sq[mlat_pkg::NUM_ANCHORS];
        longint rr[mlat_pkg::NUM_ANCHORS];
        longint a[3][3];
        longint cof[3][3];
        longint rhs[3];
        longint det;
        logic [mlat_pkg::RANGE_W-1:0] rng[mlat_pkg::NUM_ANCHORS];
        logic signed [127:0] num, cw, bw;
        logic [127:0] mag, dmag, quo;
        logic [mlat_pkg::POS_W-1:0] coord[3];
        mlat_pkg::t_out res;
        rng[0] = r.range_ref;
        rng[1] = r.range_b;
        rng[2] = r.range_c;
        rng[3] = r.range_d;
        for (int k = 0; k < mlat_pkg::NUM_ANCHORS; k++) begin
            for (int c = 0; c < mlat_pkg::NUM_AXES; c++) begin
                p[k][c] = longint'($signed(anchor_copy[k][16*c +: 16]));
            end
            sq[k] = p[k][0] * p[k][0] + p[k][1] * p[k][1] + p[k][2] * p[k][2];
            rr[k] = longint'(rng[k]) * longint'(rng[k]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                a[k][c] = 2 * (p[0][c] - p[k+1][c]);
            end
            rhs[k] = rr[k+1] - rr[0] + sq[0] - sq[k+1];
        end
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) begin
                cof[k][c] = a[(k+1)%3][(c+1)%3] * a[(k+2)%3][(c+2)%3]
                          - a[(k+1)%3][(c+2)%3] * a[(k+2)%3][(c+1)%3];
            end
        end
        det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
        if (det == 0) begin
            res = '0;
            res.singular = 1'b1;
            return res;
        end
        dmag = (det < 0) ? 128'(-det) : 128'(det);
        for (int c = 0; c < 3; c++) begin
            num = '0;
            for (int k = 0; k < 3; k++) begin
                cw = cof[k][c];
                bw = rhs[k];
                num = num + cw * bw;
            end
            mag = (num < 0) ? 128'(-num) : 128'(num);
            quo = ((mag << 9) + dmag) / (dmag << 1);
            if ((num < 0) != (det < 0)) begin
                if (quo > 128'(mlat_pkg::NEG_MAG)) quo = 128'(mlat_pkg::NEG_MAG);
                coord[c] = mlat_pkg::POS_W'(-quo);
            end else begin
                if (quo > 128'(mlat_pkg::POS_MAX)) quo = 128'(mlat_pkg::POS_MAX);
                coord[c] = quo[mlat_pkg::POS_W-1:0];
            end
        end
        res.pos_x = coord[0];
        res.pos_y = coord[1];
        res.pos_z = coord[2];
        res.singular = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic bit idle_now();
        if (items_sent >= stall_free_from && items_sent < stall_free_from + 100) return 1'b0;
        return ($urandom_range(99) < 12);
    endfunction

    // Driver: one item at a time from the pending queue.
    always @(negedge i_clk) begin
        logic nv;
        nv = i_in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_in_valid && in_taken) nv = 1'b0;
            if (!nv && pending_ranges.size() > 0 && !idle_now()) begin
                i_in <= pending_ranges.pop_front();
                nv = 1'b1;
            end
        end
        i_in_valid  <= nv;
        i_out_ready <= i_rst_n ? !idle_now() : 1'b1;
    end

    // Monitor: predicts on input acceptance and checks each result item.
    always @(posedge i_clk) begin
        mlat_pkg::t_out exp_res;
        bit             took;
        bit             busy;
        took = 1'b0;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < mlat_pkg::NUM_ANCHORS)
                    anchor_copy[i_cfg_index[AIDX_W-1:0]] = i_cfg_data;
                cfg_writes++;
                busy = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                pos_expected.push_back(solve_position(i_in));
                items_sent++;
                took = 1'b1;
                busy = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                busy = 1'b1;
                results_seen++;
                if (pos_expected.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    exp_res = pos_expected.pop_front();
                    if (o_out.singular) singular_seen++;
                    if (o_out.pos_x !== exp_res.pos_x)
                        report_mismatch($sformatf("pos_x got %0d exp %0d",
                                        o_out.pos_x, exp_res.pos_x));
                    if (o_out.pos_y !== exp_res.pos_y)
                        report_mismatch($sformatf("pos_y got %0d exp %0d",
                                        o_out.pos_y, exp_res.pos_y));
                    if (o_out.pos_z !== exp_res.pos_z)
                        report_mismatch($sformatf("pos_z got %0d exp %0d",
                                        o_out.pos_z, exp_res.pos_z));
                    if (o_out.singular !== exp_res.singular)
                        report_mismatch($sformatf("singular got %0b exp %0b",
                                        o_out.singular, exp_res.singular));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding",
                         pos_expected.size());
                $display("DONE: errors detected");
                $finish;
            end
            idle_cycles <= busy ? 0 : idle_cycles + 1;
        end
        in_taken <= took;
    end

    function automatic logic [mlat_pkg::ANCHOR_W-1:0] pack_anchor(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    task automatic write_anchor(logic [mlat_pkg::CFG_IDX_W-1:0] idx,
                                logic [mlat_pkg::ANCHOR_W-1:0] val);
        int start;
        start = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (cfg_writes == start);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_ranges.size() > 0 || i_in_valid || pos_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        mlat_pkg::t_in r;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: r = {$urandom, $urandom};
                1: r = {16'($urandom_range(200)), 16'($urandom_range(200)),
                        16'($urandom_range(200)), 16'($urandom_range(200))};
                2: r = {16'($urandom_range(60)), 16'($urandom_range(60)),
                        16'($urandom_range(60)), 16'($urandom_range(60))};
                default: r = {16'($urandom_range(65535, 60000)), 16'($urandom),
                              16'($urandom_range(10)), 16'($urandom)};
            endcase
            pending_ranges.push_back(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_taken = 1'b0;
        mismatches = 0;
        cfg_writes = 0;
        items_sent = 0;
        results_seen = 0;
        singular_seen = 0;
        idle_cycles = 0;
        stall_free_from = 150;
        anchor_copy[0] = mlat_pkg::ANCHOR_REF_RST;
        anchor_copy[1] = mlat_pkg::ANCHOR_B_RST;
        anchor_copy[2] = mlat_pkg::ANCHOR_C_RST;
        anchor_copy[3] = mlat_pkg::ANCHOR_D_RST;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_ranges.push_back('0);
        pending_ranges.push_back('1);
        pending_ranges.push_back({16'hFFFF, 16'h0, 16'h0, 16'h0});
        pending_ranges.push_back({16'h0, 16'hFFFF, 16'h0, 16'h0});
        pending_ranges.push_back({16'h0, 16'h0, 16'hFFFF, 16'h0});
        pending_ranges.push_back({16'h0, 16'h0, 16'h0, 16'hFFFF});
        pending_ranges.push_back({16'd17, 16'd17, 16'd26, 16'd26});
        pending_ranges.push_back({16'd30, 16'd0, 16'd42, 16'd42});
        pending_ranges.push_back({16'd1, 16'd30, 16'd1, 16'd1});
        pending_ranges.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        queue_random(90);
        wait_quiet();

        // Extreme corners of the coordinate range.
        write_anchor(mlat_pkg::CFG_ANCHOR_REF, pack_anchor(32767, 32767, 32767));
        write_anchor(mlat_pkg::CFG_ANCHOR_B, pack_anchor(-32768, 32767, 32767));
        write_anchor(mlat_pkg::CFG_ANCHOR_C, pack_anchor(32767, -32768, 32767));
        write_anchor(mlat_pkg::CFG_ANCHOR_D, pack_anchor(32767, 32767, -32768));
        write_anchor(mlat_pkg::CFG_IDX_W'(mlat_pkg::NUM_ANCHORS), '1);
        pending_ranges.push_back('0);
        pending_ranges.push_back('1);
        pending_ranges.push_back({16'hFFFF, 16'h0, 16'hFFFF, 16'h0});
        queue_random(80);
        wait_quiet();

        // Coincident anchors give a singular geometry.
        write_anchor(mlat_pkg::CFG_ANCHOR_REF, '0);
        write_anchor(mlat_pkg::CFG_ANCHOR_B, '0);
        write_anchor(mlat_pkg::CFG_ANCHOR_C, pack_anchor(5, 5, 5));
        write_anchor(mlat_pkg::CFG_ANCHOR_D, pack_anchor(-7, 3, 9));
        queue_random(20);
        wait_quiet();

        // Tiny determinant drives the outputs into saturation.
        write_anchor(mlat_pkg::CFG_ANCHOR_REF, pack_anchor(1, 0, 0));
        write_anchor(mlat_pkg::CFG_ANCHOR_B, pack_anchor(0, 0, 0));
        write_anchor(mlat_pkg::CFG_ANCHOR_C, pack_anchor(1, 1, 0));
        write_anchor(mlat_pkg::CFG_ANCHOR_D, pack_anchor(1, 0, 1));
        queue_random(40);
        wait_quiet();

        for (int ph = 0; ph < 3; ph++) begin
            write_anchor(mlat_pkg::CFG_ANCHOR_REF, {$urandom, $urandom});
            write_anchor(mlat_pkg::CFG_ANCHOR_B, {$urandom, $urandom});
            write_anchor(mlat_pkg::CFG_ANCHOR_C, {$urandom, $urandom});
            write_anchor(mlat_pkg::CFG_ANCHOR_D, {$urandom, $urandom});
            write_anchor(mlat_pkg::CFG_IDX_W'($urandom_range(255, mlat_pkg::NUM_ANCHORS)),
                         {$urandom, $urandom});
            queue_random(60);
            wait_quiet();
        end

        $display("Covered %0d range items, %0d results (%0d singular), %0d register writes",
                 items_sent, results_seen, singular_seen, cfg_writes);
        $display("Anchor sets: reset layout, coordinate extremes, singular, saturating, random");
        if (mismatches == 0 && pos_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pos_expected.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", pos_expected.size()));
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
